// File: sv/bgd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bgd_pkg
// Shared constants, codes and helpers for the ballistic grain deposition block.
// ---------------------------------------------------------------------------
package bgd_pkg;

    localparam int MAX_GRAINS = 1024;
    localparam int GRAIN_AW   = $clog2(MAX_GRAINS);
    localparam int COUNT_W    = GRAIN_AW + 1;
    localparam int MAX_BASE   = 256;
    localparam int MAX_STEPS  = 65535;
    localparam int STEP_W     = 16;

    // shared divider: dividend and divisor widths
    localparam int DIVN_W = 41;
    localparam int DIVD_W = 31;
    localparam int DCNT_W = $clog2(DIVN_W);

    // shared multiplier
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    typedef enum logic [2:0] {
        CFG_DIAMETER = 3'd0,
        CFG_WIDTH    = 3'd1,
        CFG_HEIGHT   = 3'd2,
        CFG_SITES    = 3'd3,
        CFG_BASE     = 3'd4,
        CFG_DT       = 3'd5,
        CFG_GRAVITY  = 3'd6,
        CFG_GAIN     = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_STORED = 2'd0,
        ST_FULL   = 2'd1,
        ST_LIMIT  = 2'd2
    } status_t;

    localparam logic [24:0] RST_DIAMETER = 25'd167772;
    localparam logic [30:0] RST_WIDTH    = 31'd16777216;
    localparam logic [30:0] RST_HEIGHT   = 31'd16777216;
    localparam logic [8:0]  RST_SITES    = 9'd100;
    localparam logic [8:0]  RST_BASE     = 9'd100;
    localparam logic [24:0] RST_DT       = 25'd16777;
    localparam logic [30:0] RST_GRAVITY  = 31'd16777216;
    localparam logic [30:0] RST_GAIN     = 31'd16777216;

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v[PROD_W-1:31] == '0 || v[PROD_W-1:31] == '1) begin
            r = v[31:0];
        end else if (v[PROD_W-1]) begin
            r = 32'sh80000000;
        end else begin
            r = 32'sh7FFFFFFF;
        end
        return r;
    endfunction

endpackage

// File: sv/ballistic_grain_deposition.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ballistic_grain_deposition
// Drops grains one at a time into a periodic box and reports where they rest.
// ---------------------------------------------------------------------------
// Input stream s_*: one transfer per grain, s_tdata[7:0] = drop site.
// Output stream m_*: one transfer per grain, rest x/y, step count, and the
// status code on m_tuser (stored, store full, step limit).
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata write one register per cycle;
// write only while the block is idle.
// Setup multiplies the width by the odd site number and squares the contact
// distance, then divides in the shared divider. Each time step scans the stored
// and base grains until one overlaps, a far candidate skipping the squares that
// a near one needs, then does the step check and Euler update, with the x wrap
// done in the shared divider.
// One multiplier and one divider are shared by all of the multiplies and divides.
// s_tready is high only while idle; a finished result sits in the output
// register, so the next grain is taken while the receiver stalls, and the
// block waits only when a second result is ready before the first leaves.
// Reset restores the configuration registers to their defaults and empties the store.
// ---------------------------------------------------------------------------
module ballistic_grain_deposition import bgd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] drop_site
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [30:0] rest_x, [62:31] rest_y, [78:63] fall_steps
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [30:0] cfg_wdata
);

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_LIM, S_LIM2, S_XDIV, S_SCAN, S_FETCH, S_DIFF,
        S_SQX, S_SQY, S_CMP, S_NOHIT, S_P0, S_P1, S_P2, S_P3, S_P4, S_P5,
        S_P6, S_PWAIT, S_STORE, S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [24:0] diam_reg;
    logic [30:0] width_reg;
    logic [30:0] height_reg;
    logic [8:0]  sites_reg;
    logic [8:0]  base_reg;
    logic [24:0] dt_reg;
    logic [30:0] grav_reg;
    logic [30:0] gain_reg;

    // working state
    logic [7:0]               site_reg;
    logic [30:0]              x_reg;
    logic signed [31:0]       y_reg;
    logic signed [31:0]       vx_reg;
    logic signed [31:0]       vy_reg;
    logic signed [31:0]       ax_reg;
    logic [STEP_W-1:0]        steps_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       idx_reg;
    logic                     base_phase_reg;
    logic [33:0]              base_c_reg;
    logic [51:0]              lim2_reg;
    logic [51:0]              acc_reg;
    logic [25:0]              dx_reg;
    logic [25:0]              dy_reg;
    logic                     far_reg;
    logic                     xneg_reg;
    logic signed [PROD_W-1:0] prod_reg;
    status_t                  status_reg;
    logic signed [31:0]       rd_x_reg;
    logic signed [31:0]       rd_y_reg;
    logic                     m_tvalid_reg;
    logic [79:0]              m_tdata_reg;
    logic [1:0]               m_tuser_reg;

    logic signed [31:0] mem_x [MAX_GRAINS];
    logic signed [31:0] mem_y [MAX_GRAINS];

    // combinational
    logic [30:0]              w_eff;
    logic [8:0]               sites_eff;
    logic [8:0]               nb;
    logic [25:0]              lim;
    logic [8:0]               odd;
    logic signed [35:0]       px, py, qx, qy, ddx, ddy;
    logic [35:0]              adx, ady;
    logic                     far;
    logic [52:0]              sq_sum;
    logic                     hit;
    logic [COUNT_W-1:0]       idx_inc;
    logic                     adv_to_base;
    logic                     adv_done;
    logic signed [32:0]       wm2x;
    logic signed [PROD_W-1:0] sh24, sh25;
    logic signed [33:0]       xs;
    logic [32:0]              xs_abs;
    logic [30:0]              x_mod;
    logic signed [MUL_W-1:0]  ma, mb;
    logic                     mem_we;
    logic                     div_start, div_busy, div_done;
    logic [DIVN_W-1:0]        div_dividend, div_quo;
    logic [DIVD_W-1:0]        div_divisor, div_rem;
    logic [7:0]               site_in;

    assign w_eff     = (width_reg == '0) ? 31'd1 : width_reg;
    assign sites_eff = (sites_reg == '0) ? 9'd1 : sites_reg;
    assign nb        = (base_reg > 9'(MAX_BASE)) ? 9'(MAX_BASE) : base_reg;
    assign lim       = {diam_reg, 1'b0};
    assign odd       = {site_reg, 1'b1};
    assign site_in   = (9'(s_tdata) >= sites_eff) ? 8'(sites_eff - 9'd1) : s_tdata;

    // overlap test in doubled coordinates so base centres stay exact
    assign px  = signed'(36'({x_reg, 1'b0}));
    assign py  = 36'(signed'({y_reg, 1'b0}));
    assign qx  = base_phase_reg ? signed'(36'(base_c_reg)) : 36'(signed'({rd_x_reg, 1'b0}));
    assign qy  = base_phase_reg ? 36'sd0 : 36'(signed'({rd_y_reg, 1'b0}));
    assign ddx = px - qx;
    assign ddy = py - qy;
    assign adx = ddx[35] ? 36'(-ddx) : 36'(ddx);
    assign ady = ddy[35] ? 36'(-ddy) : 36'(ddy);
    assign far = (adx >= 36'(lim)) || (ady >= 36'(lim));

    // sum of two squares can need one bit more than either square
    assign sq_sum = 53'(acc_reg) + 53'(prod_reg[51:0]);
    assign hit    = sq_sum < 53'(lim2_reg);

    assign idx_inc     = idx_reg + 1'b1;
    assign adv_to_base = !base_phase_reg && (idx_inc == count_reg) && (nb != '0);
    assign adv_done    = (!base_phase_reg && (idx_inc == count_reg) && (nb == '0))
                       || (base_phase_reg && (idx_inc == COUNT_W'(nb)));

    // Euler update
    assign wm2x   = signed'({2'b0, w_eff}) - signed'({1'b0, x_reg, 1'b0});
    assign sh24   = prod_reg >>> 24;
    assign sh25   = prod_reg >>> 25;
    assign xs     = 34'(PROD_W'(signed'({1'b0, x_reg})) + sh24);
    assign xs_abs = xs[33] ? 33'(-xs) : 33'(xs);
    assign x_mod  = (xneg_reg && div_rem != '0) ? w_eff - div_rem : div_rem;

    // shared multiplier operands
    always_comb begin
        ma = '0;
        mb = '0;
        case (state_reg)
            S_START: begin ma = signed'(34'(w_eff));  mb = signed'(34'(odd)); end
            S_LIM:   begin ma = signed'(34'(lim));    mb = signed'(34'(lim)); end
            S_SQX:   begin ma = signed'(34'(dx_reg)); mb = signed'(34'(dx_reg)); end
            S_SQY:   begin ma = signed'(34'(dy_reg)); mb = signed'(34'(dy_reg)); end
            S_P0:    begin ma = signed'(34'(gain_reg)); mb = 34'(wm2x); end
            S_P2:    begin ma = 34'(ax_reg); mb = signed'(34'(dt_reg)); end
            S_P3:    begin ma = -signed'(34'(grav_reg)); mb = signed'(34'(dt_reg)); end
            S_P4:    begin ma = 34'(vx_reg); mb = signed'(34'(dt_reg)); end
            S_P5:    begin ma = 34'(vy_reg); mb = signed'(34'(dt_reg)); end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign div_start    = (state_reg == S_LIM) || (state_reg == S_P5);
    assign div_dividend = (state_reg == S_LIM) ? prod_reg[DIVN_W-1:0] : DIVN_W'(xs_abs);
    assign div_divisor  = (state_reg == S_LIM) ? DIVD_W'({sites_eff, 1'b0}) : w_eff;

    bgd_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign mem_we = (state_reg == S_STORE);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_x[count_reg[GRAIN_AW-1:0]] <= signed'({1'b0, x_reg});
            mem_y[count_reg[GRAIN_AW-1:0]] <= y_reg;
        end
        rd_x_reg <= mem_x[idx_reg[GRAIN_AW-1:0]];
        rd_y_reg <= mem_y[idx_reg[GRAIN_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diam_reg   <= RST_DIAMETER;
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            sites_reg  <= RST_SITES;
            base_reg   <= RST_BASE;
            dt_reg     <= RST_DT;
            grav_reg   <= RST_GRAVITY;
            gain_reg   <= RST_GAIN;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_DIAMETER: diam_reg   <= cfg_wdata[24:0];
                CFG_WIDTH:    width_reg  <= cfg_wdata;
                CFG_HEIGHT:   height_reg <= cfg_wdata;
                CFG_SITES:    sites_reg  <= cfg_wdata[8:0];
                CFG_BASE:     base_reg   <= cfg_wdata[8:0];
                CFG_DT:       dt_reg     <= cfg_wdata[24:0];
                CFG_GRAVITY:  grav_reg   <= cfg_wdata;
                CFG_GAIN:     gain_reg   <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= ma * mb;
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // S_OUT reloads the output register itself
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        site_reg  <= site_in;
                        steps_reg <= '0;
                        vx_reg    <= '0;
                        vy_reg    <= '0;
                        state_reg <= S_START;
                    end
                end
                S_START: state_reg <= S_LIM;
                S_LIM:   state_reg <= S_LIM2;
                S_LIM2: begin
                    lim2_reg  <= prod_reg[51:0];
                    state_reg <= S_XDIV;
                end
                S_XDIV: begin
                    if (div_done) begin
                        x_reg <= div_quo[30:0];
                        y_reg <= signed'({1'b0, height_reg});
                        if (count_reg >= COUNT_W'(MAX_GRAINS)) begin
                            status_reg <= ST_FULL;
                            state_reg  <= S_OUT;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    idx_reg    <= '0;
                    base_c_reg <= 34'(diam_reg);
                    if (count_reg != '0) begin
                        base_phase_reg <= 1'b0;
                        state_reg      <= S_FETCH;
                    end else if (nb != '0) begin
                        base_phase_reg <= 1'b1;
                        state_reg      <= S_FETCH;
                    end else begin
                        state_reg <= S_NOHIT;
                    end
                end
                S_FETCH: state_reg <= S_DIFF;
                S_DIFF: begin
                    dx_reg    <= adx[25:0];
                    dy_reg    <= ady[25:0];
                    far_reg   <= far;
                    state_reg <= S_SQX;
                end
                S_SQX, S_CMP: begin
                    if (state_reg == S_SQX && !far_reg) begin
                        state_reg <= S_SQY;
                    end else if (state_reg == S_CMP && hit) begin
                        state_reg <= S_STORE;
                    end else if (adv_done) begin
                        state_reg <= S_NOHIT;
                    end else begin
                        state_reg      <= S_FETCH;
                        idx_reg        <= adv_to_base ? '0 : idx_inc;
                        base_phase_reg <= base_phase_reg | adv_to_base;
                        base_c_reg     <= adv_to_base ? 34'(diam_reg)
                                                      : base_c_reg + 34'({diam_reg, 1'b0});
                    end
                end
                S_SQY: begin
                    acc_reg   <= prod_reg[51:0];
                    state_reg <= S_CMP;
                end
                S_NOHIT: begin
                    if (steps_reg == STEP_W'(MAX_STEPS)) begin
                        status_reg <= ST_LIMIT;
                        state_reg  <= S_OUT;
                    end else begin
                        state_reg <= S_P0;
                    end
                end
                S_P0: state_reg <= S_P1;
                S_P1: begin
                    ax_reg    <= sat32(sh25);
                    state_reg <= S_P2;
                end
                S_P2: state_reg <= S_P3;
                S_P3: begin
                    vx_reg    <= sat32(PROD_W'(vx_reg) + sh24);
                    state_reg <= S_P4;
                end
                S_P4: begin
                    vy_reg    <= sat32(PROD_W'(vy_reg) + sh24);
                    state_reg <= S_P5;
                end
                S_P5: begin
                    xneg_reg  <= xs[33];
                    state_reg <= S_P6;
                end
                S_P6: begin
                    y_reg     <= sat32(PROD_W'(y_reg) + sh24);
                    state_reg <= S_PWAIT;
                end
                S_PWAIT: begin
                    if (div_done) begin
                        x_reg     <= x_mod;
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                end
                S_STORE: begin
                    count_reg  <= count_reg + 1'b1;
                    status_reg <= ST_STORED;
                    state_reg  <= S_OUT;
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0, steps_reg, y_reg, x_reg};
                        m_tuser_reg  <= status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(MAX_GRAINS))
        else $error("grain count beyond store depth");

    a_store_room: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> count_reg < COUNT_W'(MAX_GRAINS))
        else $error("store written while full");

    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PWAIT && div_done) |=> x_reg < w_eff)
        else $error("x left the box after wrap");

endmodule

// File: sv/bgd_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bgd_div
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
// ---------------------------------------------------------------------------
module bgd_div import bgd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVN_W-1:0] dividend,
    input  logic [DIVD_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [DIVN_W-1:0] quotient,
    output logic [DIVD_W-1:0] remainder
);

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DIVN_W-1:0] quo_reg;
    logic [DIVD_W-1:0] rem_reg;
    logic [DIVD_W-1:0] dvs_reg;
    logic [DIVD_W:0]   trial;
    logic [DIVD_W:0]   diff;
    logic              ge;

    assign trial = {rem_reg, quo_reg[DIVN_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIVN_W - 1);
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[DIVD_W-1:0] : trial[DIVD_W-1:0];
                quo_reg <= {quo_reg[DIVN_W-2:0], ge};
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: bench/tb_ballistic_grain_deposition.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ballistic_grain_deposition
// Self-checking bench for the grain deposition block.
// ---------------------------------------------------------------------------
// A short table of directed drops covers the step limit, out-of-range sites,
// zero site count, zero box width, an oversized base row and the register
// extremes. Random phases follow with random settings, and a final phase holds
// the output off for a long stretch while grains keep arriving. Every landing
// is predicted in the bench or given in the table, and compared field by field
// with the output stream, under random gaps on both sides.
// ---------------------------------------------------------------------------
module tb_ballistic_grain_deposition;
    import bgd_pkg::*;

    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam int     ONE         = 16777216;    // 1.0 in Q8.24

    typedef enum int {PH_LIMIT, PH_QUICK, PH_NOWIDTH, PH_WIDE_ONE, PH_WIDE_ALL} phase_t;

    typedef struct {
        logic [30:0] x;
        logic [31:0] y;
        logic [15:0] steps;
        status_t     status;
    } landing_t;

    typedef struct {
        phase_t      ph;
        logic [7:0]  site;
        bit          typed;
        landing_t    want;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [30:0] cfg_wdata;

    ballistic_grain_deposition i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // bench copy of the registers and the grain store
    logic [24:0] diam_q   = RST_DIAMETER;
    logic [30:0] width_q  = RST_WIDTH;
    logic [30:0] height_q = RST_HEIGHT;
    logic [8:0]  sites_q  = RST_SITES;
    logic [8:0]  base_q   = RST_BASE;
    logic [24:0] dt_q     = RST_DT;
    logic [30:0] grav_q   = RST_GRAVITY;
    logic [30:0] gain_q   = RST_GAIN;
    longint      pile_x [MAX_GRAINS];
    longint      pile_y [MAX_GRAINS];
    int          pile_n = 0;

    landing_t landings_due[$];
    longint   cycles = 0;
    int       mismatches = 0;
    int       landed = 0;
    int       n_full = 0;
    int       n_limit = 0;
    int       hold_ask = 0;
    bit       calm = 0;

    always begin
        aclk = 1'b1; #6;
        aclk = 1'b0; #6;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d landings outstanding",
                     cycles, landings_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // positions doubled so base centres stay exact; lim is twice the diameter
    function automatic bit overlaps(input longint ax, input longint ay,
                                    input longint bx, input longint by, input longint lim);
        longint dx, dy;
        dx = ax - bx;
        dy = ay - by;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dx >= lim || dy >= lim) return 0;
        return dx * dx + dy * dy < lim * lim;
    endfunction

    function automatic bit touching(input longint x, input longint y);
        longint lim;
        int     nb;
        lim = 2 * longint'(diam_q);
        nb  = (base_q > MAX_BASE) ? MAX_BASE : int'(base_q);
        for (int j = 0; j < pile_n; j++)
            if (overlaps(2 * x, 2 * y, 2 * pile_x[j], 2 * pile_y[j], lim)) return 1;
        for (int j = 0; j < nb; j++)
            if (overlaps(2 * x, 2 * y, longint'(diam_q) * (2 * j + 1), 0, lim)) return 1;
        return 0;
    endfunction

    function automatic landing_t drop_grain(input logic [7:0] site);
        longint   w, x, y, vx, vy, dt, ax, ay, sites, s;
        int       steps;
        bit       done;
        landing_t r;
        w     = (width_q == 0) ? 1 : longint'(width_q);
        sites = (sites_q == 0) ? 1 : longint'(sites_q);
        s     = longint'(site);
        if (s >= sites) s = sites - 1;
        x     = (w * (2 * s + 1)) / (2 * sites);
        y     = longint'(height_q);
        vx    = 0;
        vy    = 0;
        dt    = longint'(dt_q);
        steps = 0;
        done  = 0;
        if (pile_n >= MAX_GRAINS) begin
            r.status = ST_FULL;
        end else begin
            while (!done) begin
                if (touching(x, y)) begin
                    pile_x[pile_n] = x;
                    pile_y[pile_n] = y;
                    pile_n++;
                    r.status = ST_STORED;
                    done = 1;
                end else if (steps >= MAX_STEPS) begin
                    r.status = ST_LIMIT;
                    done = 1;
                end else begin
                    ax = clamp32((longint'(gain_q) * (w - 2 * x)) >>> 25);
                    ay = -longint'(grav_q);
                    vx = clamp32(vx + ((ax * dt) >>> 24));
                    vy = clamp32(vy + ((ay * dt) >>> 24));
                    x  = (x + ((vx * dt) >>> 24)) % w;
                    if (x < 0) x += w;
                    y  = clamp32(y + ((vy * dt) >>> 24));
                    steps++;
                end
            end
        end
        r.x     = x[30:0];
        r.y     = y[31:0];
        r.steps = steps[15:0];
        return r;
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input int val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= 31'(val);
        case (idx)
            CFG_DIAMETER: diam_q   = 25'(val);
            CFG_WIDTH:    width_q  = 31'(val);
            CFG_HEIGHT:   height_q = 31'(val);
            CFG_SITES:    sites_q  = 9'(val);
            CFG_BASE:     base_q   = 9'(val);
            CFG_DT:       dt_q     = 25'(val);
            CFG_GRAVITY:  grav_q   = 31'(val);
            default:      gain_q   = 31'(val);
        endcase
        @(posedge aclk);
    endtask

    task automatic write_all(input int d, input int w, input int h,
                             input int ns, input int nb, input int dt,
                             input int g, input int k);
        write_reg(CFG_DIAMETER, d);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_SITES, ns);
        write_reg(CFG_BASE, nb);
        write_reg(CFG_DT, dt);
        write_reg(CFG_GRAVITY, g);
        write_reg(CFG_GAIN, k);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain;
        while (landings_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_phase(input phase_t ph);
        drain();
        case (ph)
            // nothing to land on and no forces: the grain hangs until the step cap
            PH_LIMIT: begin
                write_reg(CFG_BASE, 0);
                write_reg(CFG_GRAVITY, 0);
                write_reg(CFG_GAIN, 0);
                cfg_wr_en <= 1'b0;
                @(posedge aclk);
            end
            PH_QUICK:    write_all(ONE / 10, ONE, ONE / 10 * 3, 10, 12, ONE / 20, ONE, ONE);
            PH_NOWIDTH:  write_all(ONE / 10, 0, ONE / 5, 7, 2, ONE / 20, ONE, ONE);
            PH_WIDE_ONE: write_all(ONE, 32'h7FFFFFFF, 0, 0, 300, ONE, 32'h7FFFFFFF,
                                   32'h7FFFFFFF);
            default:     write_reg(CFG_SITES, 256);
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // one grain transfer; the expectation is queued at the accepting edge
    task automatic drop(input logic [7:0] site, input bit typed, input landing_t want);
        landing_t got;
        s_tvalid <= 1'b1;
        s_tdata  <= site;
        do @(posedge aclk); while (!s_tready);
        got = drop_grain(site);
        landings_due.push_back(typed ? want : got);
        if (!calm && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // output side: random stalls, a calm stretch, and long hold-offs on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_ask != 0) begin
                m_tready <= 1'b0;
                repeat (hold_ask) @(posedge aclk);
                hold_ask = 0;
            end
            m_tready <= !aresetn ? 1'b0 : (calm || $urandom_range(99) >= 31);
        end
    end

    always @(posedge aclk) begin
        landing_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (landings_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected landing x=%0d y=%0d", 
                                               m_tdata[30:0], $signed(m_tdata[62:31]));
            end else begin
                e = landings_due.pop_front();
                landed++;
                if (m_tuser == ST_FULL) n_full++;
                if (m_tuser == ST_LIMIT) n_limit++;
                if (m_tdata[30:0] !== e.x || m_tdata[62:31] !== e.y
                        || m_tdata[78:63] !== e.steps || m_tuser !== e.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Landing %0d: want x=%0d y=%0d steps=%0d st=%0d, got x=%0d y=%0d steps=%0d st=%0d",
                                 landed, e.x, $signed(e.y), e.steps, e.status,
                                 m_tdata[30:0], $signed(m_tdata[62:31]), m_tdata[78:63], m_tuser);
                end
            end
        end
    end

    initial begin
        row_t     plan[$];
        landing_t none;
        phase_t   cur;
        int       d, w, h, nb, ns;

        none = '{x: 0, y: 0, steps: 0, status: ST_STORED};
        plan = '{
            '{PH_LIMIT,    8'd0,   1, '{31'd83886, 32'd16777216, 16'd65535, ST_LIMIT}},
            '{PH_QUICK,    8'd0,   0, none},
            '{PH_QUICK,    8'd9,   0, none},
            '{PH_QUICK,    8'd10,  0, none},
            '{PH_QUICK,    8'd255, 0, none},
            '{PH_QUICK,    8'd5,   0, none},
            '{PH_QUICK,    8'd5,   0, none},
            '{PH_QUICK,    8'd5,   0, none},
            '{PH_QUICK,    8'd5,   0, none},
            '{PH_QUICK,    8'd170, 0, none},
            '{PH_NOWIDTH,  8'd3,   0, none},
            '{PH_NOWIDTH,  8'd200, 0, none},
            '{PH_WIDE_ONE, 8'd0,   1, '{31'd1073741823, 32'd0, 16'd0, ST_STORED}},
            '{PH_WIDE_ONE, 8'd255, 1, '{31'd1073741823, 32'd0, 16'd0, ST_STORED}},
            '{PH_WIDE_ALL, 8'd0,   1, '{31'd4194303, 32'd0, 16'd0, ST_STORED}},
            '{PH_WIDE_ALL, 8'd255, 0, none},
            '{PH_WIDE_ALL, 8'd85,  0, none}
        };

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = CFG_DIAMETER;
        cfg_wdata = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        cur = PH_LIMIT;
        set_phase(cur);
        foreach (plan[i]) begin
            if (plan[i].ph != cur) begin
                s_tvalid <= 1'b0;
                cur = plan[i].ph;
                set_phase(cur);
            end
            drop(plan[i].site, plan[i].typed, plan[i].want);
        end
        s_tvalid <= 1'b0;

        // random settings kept short of tunnelling through the base row
        for (int p = 0; p < 4; p++) begin
            drain();
            d  = $urandom_range(ONE / 16, ONE / 8);
            w  = $urandom_range(ONE / 2, 2 * ONE);
            nb = w / d + 2;
            h  = (p == 0) ? 0 : $urandom_range(0, ONE / 5 * 2);
            ns = $urandom_range(1, 256);
            write_all(d, w, h, ns, nb, $urandom_range(ONE / 33, ONE / 20),
                      $urandom_range(ONE / 2, ONE / 2 * 3), $urandom_range(0, 4 * ONE));
            for (int i = 0; i < 20; i++) begin
                calm = (p == 2);
                drop(8'($urandom_range(0, 255)), 1'b0, none);
            end
            calm = 0;
            s_tvalid <= 1'b0;
        end

        // keep offering grains behind a long output hold-off so the input stalls
        drain();
        write_all(ONE / 16, ONE, 0, 16, 16, ONE / 20, ONE, ONE);
        hold_ask = 3000;
        repeat (8) drop(8'($urandom_range(0, 255)), 1'b0, none);
        s_tvalid <= 1'b0;

        drain();
        repeat (100) @(posedge aclk);
        mismatches += landings_due.size();
        $display("Checked %0d landings: %0d at the step cap, %0d refused with the store full.",
                 landed, n_limit, n_full);
        $display("Phases: step cap, quick falls, zero width, wide extremes, 4 random, hold-off.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
